### hdl/shift_insert_list_buffer_macros.svh
// Assertion macros for the shift insert list buffer.
`ifndef SHIFT_INSERT_LIST_BUFFER_MACROS_SVH
`define SHIFT_INSERT_LIST_BUFFER_MACROS_SVH
`ifndef SYNTH
`define SIL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sil assertion failed");
`define SIL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sil assertion failed");
`else
`define SIL_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SIL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### hdl/sil_pkg.sv
// Types and constants shared by the shift insert list buffer.
`default_nettype none
package sil_pkg;
	localparam int CAPACITY = 16;
	localparam int DATA_WIDTH = 32;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = $clog2(CAPACITY);

	typedef enum logic [2:0] {
		OP_APPEND     = 3'd0,
		OP_DROP_LAST  = 3'd1,
		OP_INSERT_AT  = 3'd2,
		OP_REMOVE_AT  = 3'd3,
		OP_INSERT_MID = 3'd4,
		OP_REMOVE_MID = 3'd5,
		OP_READ       = 3'd6
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef struct packed {
		op_t                   operation;
		logic [4:0]            position;
		logic [DATA_WIDTH-1:0] item_value;
	} req_t;

	typedef struct packed {
		status_t               status;
		logic [CNT_W-1:0]      element_count;
		logic [DATA_WIDTH-1:0] read_value;
	} rsp_t;

	typedef struct packed {
		logic             ins;
		logic             rem;
		logic [CNT_W-1:0] tgt;
	} shift_t;

	typedef struct packed {
		shift_t           shift;
		logic             rd_en;
		status_t          status;
		logic [CNT_W-1:0] count;
	} ctl_t;
endpackage
`default_nettype wire

### hdl/sil_cell.sv
// One list entry; loads the new item or a neighbor's value on insert and remove shifts.
`default_nettype none
module sil_cell #(
	parameter int INDEX = 0
) (
	input  wire logic                           clk,
	input  wire sil_pkg::shift_t                shift,
	input  wire logic [sil_pkg::DATA_WIDTH-1:0] new_value,
	input  wire logic [sil_pkg::DATA_WIDTH-1:0] left_value,
	input  wire logic [sil_pkg::DATA_WIDTH-1:0] right_value,
	output logic      [sil_pkg::DATA_WIDTH-1:0] value
);
	localparam logic [sil_pkg::CNT_W-1:0] IDX = sil_pkg::CNT_W'(INDEX);

	logic [sil_pkg::DATA_WIDTH-1:0] value_q;

	always_ff @(posedge clk) begin
		if (shift.ins && shift.tgt == IDX) begin
			value_q <= new_value;
		end else if (shift.ins && shift.tgt < IDX) begin
			value_q <= left_value;
		end else if (shift.rem && shift.tgt <= IDX) begin
			value_q <= right_value;
		end
	end

	assign value = value_q;
endmodule
`default_nettype wire

### hdl/sil_ctrl.sv
// Request decode: target position, bounds checks, status and next count.
`default_nettype none
module sil_ctrl (
	input  wire logic                      fire,
	input  wire sil_pkg::req_t             req,
	input  wire logic [sil_pkg::CNT_W-1:0] count,
	output sil_pkg::ctl_t                  ctl
);
	logic                      ins_req;
	logic                      rem_req;
	logic                      rd_req;
	logic [sil_pkg::CNT_W-1:0] tgt;

	always_comb begin
		ins_req = 1'b0;
		rem_req = 1'b0;
		rd_req  = 1'b0;
		tgt     = count;
		unique case (req.operation)
			sil_pkg::OP_APPEND: begin
				ins_req = 1'b1;
			end
			sil_pkg::OP_DROP_LAST: begin
				rem_req = 1'b1;
				tgt     = count - 1'b1;
			end
			sil_pkg::OP_INSERT_AT: begin
				ins_req = 1'b1;
				tgt     = req.position;
			end
			sil_pkg::OP_REMOVE_AT: begin
				rem_req = 1'b1;
				tgt     = req.position;
			end
			sil_pkg::OP_INSERT_MID: begin
				ins_req = 1'b1;
				tgt     = count >> 1;
			end
			sil_pkg::OP_REMOVE_MID: begin
				rem_req = 1'b1;
				tgt     = count >> 1;
			end
			sil_pkg::OP_READ: begin
				rd_req = 1'b1;
				tgt    = req.position;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		ctl           = '0;
		ctl.status    = sil_pkg::ST_OK;
		ctl.count     = count;
		ctl.shift.tgt = tgt;
		if (fire) begin
			if (ins_req) begin
				if (tgt > count) begin
					ctl.status = sil_pkg::ST_RANGE;
				end else if (count >= sil_pkg::CNT_W'(sil_pkg::CAPACITY)) begin
					ctl.status = sil_pkg::ST_FULL;
				end else begin
					ctl.shift.ins = 1'b1;
					ctl.count     = count + 1'b1;
				end
			end else if (rem_req || rd_req) begin
				if (count == '0) begin
					ctl.status = sil_pkg::ST_EMPTY;
				end else if (tgt >= count) begin
					ctl.status = sil_pkg::ST_RANGE;
				end else if (rem_req) begin
					ctl.shift.rem = 1'b1;
					ctl.count     = count - 1'b1;
				end else begin
					ctl.rd_en = 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

### hdl/shift_insert_list_buffer.sv
// Top level: fixed-capacity ordered list built from a row of shifting cells.
//
//  channel   handshake         payload
//  request   start / busy      req  (operation, position, item_value)
//  result    done (1 cycle)    rsp  (status, element_count, read_value)
//
// One request per cycle: busy stays low, and the cells from the target up shift in parallel.
// The result appears on rsp with done in the cycle after the request is taken.
// Reset clears the count and done; entry contents are left as they are.
// The receiver cannot stall; each result is flagged by done for exactly one cycle.
`default_nettype none
`include "shift_insert_list_buffer_macros.svh"
module shift_insert_list_buffer (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire sil_pkg::req_t req,
	output logic               done,
	output sil_pkg::rsp_t      rsp
);
	logic                           fire;
	logic [sil_pkg::CNT_W-1:0]      count_q;
	logic                           done_q;
	sil_pkg::rsp_t                  rsp_q;
	sil_pkg::ctl_t                  ctl;
	logic [sil_pkg::DATA_WIDTH-1:0] cells [sil_pkg::CAPACITY];
	logic [sil_pkg::DATA_WIDTH-1:0] rd_word;

	assign busy = 1'b0;
	assign fire = start && !busy;

	sil_ctrl u_ctrl (
		.fire  (fire),
		.req   (req),
		.count (count_q),
		.ctl   (ctl)
	);

	for (genvar g = 0; g < sil_pkg::CAPACITY; g++) begin : g_cell
		logic [sil_pkg::DATA_WIDTH-1:0] left_w;
		logic [sil_pkg::DATA_WIDTH-1:0] right_w;
		if (g == 0) begin : g_first
			assign left_w = cells[g];
		end else begin : g_left
			assign left_w = cells[g-1];
		end
		if (g == sil_pkg::CAPACITY - 1) begin : g_last
			assign right_w = cells[g];
		end else begin : g_right
			assign right_w = cells[g+1];
		end
		sil_cell #(
			.INDEX (g)
		) u_cell (
			.clk         (clk),
			.shift       (ctl.shift),
			.new_value   (req.item_value),
			.left_value  (left_w),
			.right_value (right_w),
			.value       (cells[g])
		);
	end

	assign rd_word = ctl.rd_en ? cells[req.position[sil_pkg::IDX_W-1:0]] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= ctl.count;
			done_q  <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q.status        <= ctl.status;
			rsp_q.element_count <= ctl.count;
			rsp_q.read_value    <= rd_word;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	`SIL_ASSERT_SAME(a_count_bound, clk, arst_n, 1'b1, count_q <= sil_pkg::CNT_W'(sil_pkg::CAPACITY))
	`SIL_ASSERT_NEXT(a_done_follows, clk, arst_n, 1'b1, done == $past(fire))
	`SIL_ASSERT_NEXT(a_ins_grows, clk, arst_n, ctl.shift.ins, count_q == $past(count_q) + 1'b1)
	`SIL_ASSERT_SAME(a_fail_zero, clk, arst_n, done && rsp.status != sil_pkg::ST_OK, rsp.read_value == '0)
endmodule
`default_nettype wire

### tb/shift_insert_list_buffer_tb.sv
// Self-checking testbench for the shift insert list buffer: directed and random requests.
`timescale 1ns / 100ps
module shift_insert_list_buffer_tb;
	import sil_pkg::*;

	localparam logic [2:0] NOP_CODE = 3'd7;
	localparam int RANDOM_WORDS = 650;
	localparam int LIMIT_CYCLES = 200000;
	localparam int TAIL_CYCLES = 8;

	class list_scoreboard;
		logic [DATA_WIDTH-1:0] slots [CAPACITY];
		int unsigned fill;
		rsp_t awaited [$];
		int fails;

		function new();
			fill = 0;
			fails = 0;
		endfunction

		function status_t place(int unsigned at, logic [DATA_WIDTH-1:0] word);
			if (at > fill)
				return ST_RANGE;
			if (fill >= CAPACITY)
				return ST_FULL;
			for (int unsigned i = fill; i > at; i--)
				slots[i] = slots[i - 1];
			slots[at] = word;
			fill++;
			return ST_OK;
		endfunction

		function status_t take(int unsigned at);
			if (fill == 0)
				return ST_EMPTY;
			if (at >= fill)
				return ST_RANGE;
			for (int unsigned i = at; i + 1 < fill; i++)
				slots[i] = slots[i + 1];
			fill--;
			return ST_OK;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function void note_request(req_t r);
			rsp_t want;
			want = '0;
			case (r.operation)
			OP_APPEND: want.status = place(fill, r.item_value);
			OP_DROP_LAST: want.status = (fill == 0) ? ST_EMPTY : take(fill - 1);
			OP_INSERT_AT: want.status = place(r.position, r.item_value);
			OP_REMOVE_AT: want.status = take(r.position);
			OP_INSERT_MID: want.status = place(fill / 2, r.item_value);
			OP_REMOVE_MID: want.status = (fill == 0) ? ST_EMPTY : take(fill / 2);
			OP_READ: begin
				if (fill == 0)
					want.status = ST_EMPTY;
				else if (r.position >= fill)
					want.status = ST_RANGE;
				else
					want.read_value = slots[r.position];
			end
			default: ;
			endcase
			want.element_count = CNT_W'(fill);
			awaited.push_back(want);
		endfunction

		function void check_result(rsp_t got);
			rsp_t want;
			if (awaited.size() == 0) begin
				$display("%0t: unexpected result: status %0d count %0d value %h",
					$time, got.status, got.element_count, got.read_value);
				fails++;
				return;
			end
			want = awaited.pop_front();
			if (got.status !== want.status) begin
				$display("%0t: status expected %0d got %0d", $time, want.status, got.status);
				fails++;
			end
			if (got.element_count !== want.element_count) begin
				$display("%0t: element_count expected %0d got %0d",
					$time, want.element_count, got.element_count);
				fails++;
			end
			if (got.read_value !== want.read_value) begin
				$display("%0t: read_value expected %h got %h",
					$time, want.read_value, got.read_value);
				fails++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t req = '0;
	logic busy;
	logic done;
	rsp_t rsp;
	int cycles = 0;

	list_scoreboard sb = new();

	shift_insert_list_buffer i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_result(rsp);
			if (start && !busy)
				sb.note_request(req);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("** shift_insert_list_buffer: FAILED **");
			$finish;
		end
	end

	function automatic req_t mk(op_t op, int unsigned at, logic [DATA_WIDTH-1:0] word);
		req_t r;
		r.operation = op;
		r.position = 5'(at);
		r.item_value = word;
		return r;
	endfunction

	function automatic int unsigned idle_gap();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 50)
			return 0;
		if (roll < 85)
			return $urandom_range(3, 1);
		if (roll < 97)
			return $urandom_range(10, 4);
		return $urandom_range(40, 20);
	endfunction

	// growing selects the cuts_grow operation mix, otherwise cuts_shrink; neither favors inserts over removes
	function automatic req_t pick_request(bit growing);
		int unsigned cuts_grow [7] = '{20, 50, 65, 80, 87, 92, 97};
		int unsigned cuts_shrink [7] = '{5, 15, 20, 35, 65, 80, 97};
		int unsigned roll;
		int unsigned k;
		int unsigned bound;
		req_t r;
		roll = $urandom_range(99);
		k = 0;
		for (int i = 0; i < 7; i++)
			if (roll >= (growing ? cuts_grow[i] : cuts_shrink[i]))
				k++;
		r.operation = (k == 7) ? op_t'(NOP_CODE) : op_t'(3'(k));
		if (r.operation inside {OP_APPEND, OP_INSERT_AT, OP_INSERT_MID})
			bound = sb.fill;
		else
			bound = (sb.fill == 0) ? 0 : sb.fill - 1;
		if ($urandom_range(9) == 0)
			r.position = 5'($urandom_range(31));
		else
			r.position = 5'($urandom_range(bound));
		case ($urandom_range(9))
		0: r.item_value = '0;
		1: r.item_value = '1;
		default: r.item_value = $urandom;
		endcase
		return r;
	endfunction

	task automatic send_word(req_t r, int unsigned gap);
		if (gap != 0) begin
			if (start)
				start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	task automatic hold_until_drained();
		start <= 1'b0;
		@(negedge clk);
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	initial begin
		bit growing;
		int unsigned burst_left;
		int unsigned gap;
		growing = 1'b1;
		burst_left = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty list, bad positions, no-op code, shifts at both ends and the middle
		send_word(mk(OP_DROP_LAST, 0, '0), 0);
		send_word(mk(OP_REMOVE_MID, 0, '0), 0);
		send_word(mk(OP_REMOVE_AT, 31, '0), 0);
		send_word(mk(OP_READ, 0, '0), 0);
		send_word(mk(OP_INSERT_AT, 1, 32'h0000_0001), 0);
		send_word(mk(op_t'(NOP_CODE), 31, '1), 0);
		send_word(mk(OP_INSERT_MID, 0, 32'h1111_1111), 0);
		send_word(mk(OP_APPEND, 0, '0), 0);
		send_word(mk(OP_APPEND, 16, '1), 0);
		send_word(mk(OP_INSERT_AT, 0, 32'ha5a5_a5a5), 0);
		send_word(mk(OP_INSERT_AT, 4, 32'h5a5a_5a5a), 0);
		send_word(mk(OP_INSERT_MID, 0, 32'h1234_5678), 0);
		send_word(mk(OP_INSERT_AT, 7, 32'hdead_beef), 0);
		send_word(mk(OP_READ, 0, '0), 0);
		send_word(mk(OP_READ, 5, '0), 0);
		send_word(mk(OP_READ, 6, '0), 0);
		send_word(mk(OP_READ, 31, '0), 0);
		send_word(mk(OP_REMOVE_AT, 6, '0), 0);
		send_word(mk(OP_REMOVE_AT, 1, '0), 0);
		send_word(mk(OP_REMOVE_MID, 0, '0), 0);
		send_word(mk(OP_DROP_LAST, 0, '0), 0);
		send_word(mk(OP_REMOVE_AT, 0, '0), 0);
		send_word(mk(OP_READ, 0, '0), 0);
		send_word(mk(op_t'(NOP_CODE), 0, '0), 0);
		hold_until_drained();

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (burst_left == 0 && $urandom_range(59) == 0)
				burst_left = $urandom_range(40, 20);
			if (burst_left != 0) begin
				gap = 0;
				burst_left--;
			end else begin
				gap = idle_gap();
			end
			if (sb.fill >= CAPACITY && $urandom_range(3) == 0)
				growing = 1'b0;
			else if (sb.fill == 0 && $urandom_range(3) == 0)
				growing = 1'b1;
			else if ($urandom_range(39) == 0)
				growing = ~growing;
			send_word(pick_request(growing), gap);
			if (n == RANDOM_WORDS / 2 || $urandom_range(149) == 0)
				hold_until_drained();
		end

		hold_until_drained();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (sb.fails == 0 && sb.pending() == 0)
			$display("** shift_insert_list_buffer: PASSED **");
		else
			$display("** shift_insert_list_buffer: FAILED **");
		$finish;
	end
endmodule
